// ----- rtl/ubl_pkg.sv -----
// ----------------------------------------------------------------------------
// ubl_pkg
// Shared types and constants of the unordered bounded list.
// ----------------------------------------------------------------------------
package ubl_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int VALUE_W   = 32;
	localparam int OP_W      = 2;
	localparam int ST_W      = 2;
	localparam int POS_W     = 5;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_SEARCH = 2'd2
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_REPLY
	} state_t;

	typedef struct packed {
		logic shift;
		logic ins;
	} cell_ctrl_t;

endpackage

// ----- rtl/unordered_bounded_list.sv -----
// ----------------------------------------------------------------------------
// unordered_bounded_list
// Unordered list of up to DEPTH signed values with insert, swap-remove delete
// and search, held in a ring of cells that rotates during a scan.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream: s_tuser carries the operation and s_tdata
// the value. Each request gives exactly one result on the m_ stream: m_tuser
// carries the status, m_tdata the position and the count after the request.
// Insert and unused operations pass from the accepted transfer through the
// reply state to the output register. Delete and search on a non-empty list
// first rotate the occupied ring once through the head cell, one entry per cycle.
// The head cell's comparator checks one entry per cycle, which sets that rate.
// A new request is accepted once the previous one has been handed to the
// output register, even while that result is still waiting to be taken.
// If the receiver stalls, the result is held in the output register and the
// following result waits until the register is free.
// Reset empties the list; stored values are undefined until written.
// ----------------------------------------------------------------------------
module unordered_bounded_list #(
	parameter int DEPTH = ubl_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] item_value
	input  logic [1:0]  s_tuser,  // [1:0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [4:0] position, [9:5] count_after, [15:10] zero
	output logic [1:0]  m_tuser   // [1:0] status
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int VW = ubl_pkg::VALUE_W;
	localparam int PW = ubl_pkg::POS_W;

	ubl_pkg::state_t     state_q, state_d;
	logic [CW-1:0]       count_q;
	logic                m_tvalid_q;

	ubl_pkg::op_t        op_q;
	logic [VW-1:0]       key_q;
	logic [VW-1:0]       last_q;
	logic [CW-1:0]       step_q;
	logic [CW-1:0]       pos_q;
	logic                found_q;
	ubl_pkg::status_t    res_status_q;
	logic [CW-1:0]       res_pos_q;
	logic [CW-1:0]       res_count_q;
	ubl_pkg::status_t    out_status_q;
	logic [PW-1:0]       out_pos_q;
	logic [PW-1:0]       out_count_q;

	logic [VW-1:0]       cell_val [DEPTH];
	ubl_pkg::cell_ctrl_t cell_ctrl;
	ubl_pkg::op_t        in_op;
	logic [VW-1:0]       in_val;
	logic                accept;
	logic                room;
	logic                do_ins;
	logic [VW-1:0]       head;
	logic                match;
	logic [VW-1:0]       feed;
	logic                scan_end;
	logic                fin_found;
	logic [CW-1:0]       fin_pos;
	logic                load_out;

	assign in_op  = ubl_pkg::op_t'(s_tuser);
	assign in_val = s_tdata[VW-1:0];
	assign accept = s_tvalid && s_tready;
	assign room   = (count_q < CW'(DEPTH));
	assign do_ins = accept && (in_op == ubl_pkg::OP_INSERT) && room;

	assign head      = cell_val[0];
	assign match     = !found_q && (head == key_q);
	assign feed      = ((op_q == ubl_pkg::OP_DELETE) && match) ? last_q : head;
	assign scan_end  = (state_q == ubl_pkg::S_SCAN) && (step_q == count_q - CW'(1));
	assign fin_found = found_q || match;
	assign fin_pos   = found_q ? pos_q : (match ? step_q : count_q);

	assign cell_ctrl.shift = (state_q == ubl_pkg::S_SCAN);
	assign cell_ctrl.ins   = do_ins;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [VW-1:0] nxt;
		if (g < DEPTH - 1) begin : g_mid
			assign nxt = cell_val[g + 1];
		end else begin : g_end
			assign nxt = feed;
		end
		ubl_cell #(
			.IDX (g),
			.CW  (CW)
		) u_cell (
			.clk   (clk),
			.ctrl  (cell_ctrl),
			.count (count_q),
			.wdata (in_val),
			.nxt   (nxt),
			.feed  (feed),
			.value (cell_val[g])
		);
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ubl_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (((in_op == ubl_pkg::OP_DELETE) || (in_op == ubl_pkg::OP_SEARCH))
							&& (count_q != '0)) begin
						state_d = ubl_pkg::S_SCAN;
					end else begin
						state_d = ubl_pkg::S_REPLY;
					end
				end
			end
			ubl_pkg::S_SCAN: begin
				if (scan_end) begin
					state_d = ubl_pkg::S_REPLY;
				end
			end
			ubl_pkg::S_REPLY: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ubl_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ubl_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ubl_pkg::S_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_ins) begin
				count_q <= count_q + CW'(1);
			end else if (scan_end && (op_q == ubl_pkg::OP_DELETE) && fin_found) begin
				count_q <= count_q - CW'(1);
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= in_op;
			key_q       <= in_val;
			step_q      <= '0;
			found_q     <= 1'b0;
			pos_q       <= count_q;
			res_pos_q   <= count_q;
			res_count_q <= count_q;
			unique case (in_op)
				ubl_pkg::OP_INSERT: begin
					if (room) begin
						res_status_q <= ubl_pkg::ST_OK;
						res_count_q  <= count_q + CW'(1);
						last_q       <= in_val;
					end else begin
						res_status_q <= ubl_pkg::ST_FULL;
					end
				end
				ubl_pkg::OP_DELETE, ubl_pkg::OP_SEARCH: begin
					res_status_q <= ubl_pkg::ST_NOTFOUND;
				end
				default: begin
					res_status_q <= ubl_pkg::ST_OK;
				end
			endcase
		end else if (state_q == ubl_pkg::S_SCAN) begin
			step_q <= step_q + CW'(1);
			if (match) begin
				found_q <= 1'b1;
				pos_q   <= step_q;
			end
			// The entry that ends up just below the old tail becomes the new tail.
			// A delete that finds nothing keeps the old tail, which is at the head
			// in the last step of the scan.
			if (op_q == ubl_pkg::OP_DELETE) begin
				if (scan_end && !fin_found) begin
					last_q <= head;
				end else if (step_q == count_q - CW'(2)) begin
					last_q <= feed;
				end
			end
			if (scan_end) begin
				res_status_q <= fin_found ? ubl_pkg::ST_OK : ubl_pkg::ST_NOTFOUND;
				res_pos_q    <= fin_pos;
				res_count_q  <= ((op_q == ubl_pkg::OP_DELETE) && fin_found)
				                ? count_q - CW'(1) : count_q;
			end
		end
		if (load_out) begin
			out_status_q <= res_status_q;
			out_pos_q    <= PW'(res_pos_q);
			out_count_q  <= PW'(res_count_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, out_count_q, out_pos_q};
	assign m_tuser  = out_status_q;

endmodule

// ----- rtl/ubl_cell.sv -----
// ----------------------------------------------------------------------------
// ubl_cell
// One storage cell of the list ring: takes a written value, its neighbour's or the fed-back one.
// ----------------------------------------------------------------------------
module ubl_cell #(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  logic                          clk,
	input  ubl_pkg::cell_ctrl_t           ctrl,
	input  logic [CW-1:0]                 count,
	input  logic [ubl_pkg::VALUE_W-1:0]   wdata,
	input  logic [ubl_pkg::VALUE_W-1:0]   nxt,
	input  logic [ubl_pkg::VALUE_W-1:0]   feed,
	output logic [ubl_pkg::VALUE_W-1:0]   value
);

	logic [ubl_pkg::VALUE_W-1:0] value_q;
	logic                        is_last;
	logic                        is_slot;

	// The cell at the end of the occupied ring takes the value fed back from the head.
	assign is_last = (count == CW'(IDX + 1));
	assign is_slot = (count == CW'(IDX));

	always_ff @(posedge clk) begin
		if (ctrl.ins && is_slot) begin
			value_q <= wdata;
		end else if (ctrl.shift) begin
			value_q <= is_last ? feed : nxt;
		end
	end

	assign value = value_q;

endmodule
